// ===== sv/gcd_pkg.sv =====
// Package with shared types and constants for the genome compatibility distance block.
`default_nettype none
package gcd_pkg;
  localparam int unsigned MAX_EDGES_DEF = 256;
  localparam logic [1:0] KIND_FIRST   = 2'd0;
  localparam logic [1:0] KIND_SECOND  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;
  localparam logic [1:0] CFG_DFAC   = 2'd0;
  localparam logic [1:0] CFG_WFAC   = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MERGE, ST_PROD, ST_MUL, ST_DIV, ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [9:0]  disjoint_count;
    logic [8:0]  matching_count;
    logic        no_matches;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/gcd_if.sv =====
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface gcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] innovation_id;
  logic signed [15:0] edge_weight;
  modport source (output valid, kind, innovation_id, edge_weight, input ready);
  modport sink (input valid, kind, innovation_id, edge_weight, output ready);
endinterface

interface gcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [9:0]  disjoint_count;
  logic [8:0]  matching_count;
  logic        no_matches;
  modport source (output valid, distance, disjoint_count, matching_count, no_matches,
                  input ready);
  modport sink (input valid, distance, disjoint_count, matching_count, no_matches,
                output ready);
endinterface
`default_nettype wire

// ===== sv/genome_compatibility_distance_top.sv =====
// Top level of the genome compatibility distance block.
// Input items arrive on in_* (valid/ready). Kind 0 and 1 append an
// (innovation id, weight) pair to the first or second list, one item per
// cycle while the block is idle, each written into its own synchronous
// memory; appends beyond MAX_EDGES are dropped. Kind 2 merges the two
// lists and yields one result item on out_*; kind 3 is ignored. After the
// compute item is accepted the block issues the first read, then takes the
// merge steps (at most first_count + second_count) and a closing step,
// forms the products, starts the divider, runs two restoring divisions one
// after the other and finally sums and saturates. The lists are then empty
// again. The user must write configuration on cfg_* only while the block
// is idle; the block itself does not enforce this. Reset clears the list
// lengths and loads the register defaults; the memory contents are left
// undefined. A stalled receiver holds the result in the output register
// and the block takes no new item until it goes.
`default_nettype none
module genome_compatibility_distance_top import gcd_pkg::*; #(
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gcd_in_if.sink     in_ch,
  gcd_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DCW = CW + 1;
  localparam int unsigned SW = 17 + AW;

  logic [15:0] dfac_r, wfac_r;
  logic [8:0]  thresh_r;
  logic [15:0] id_a_mem [MAX_EDGES];
  logic [15:0] w_a_mem  [MAX_EDGES];
  logic [15:0] id_b_mem [MAX_EDGES];
  logic [15:0] w_b_mem  [MAX_EDGES];
  logic [CW-1:0] cnt_a_r, cnt_b_r, i_r, i_nxt, j_r, j_nxt;
  logic [15:0] ida_q, wa_q, idb_q, wb_q;
  state_t state_r, state_nxt;
  logic [DCW-1:0] disj_r, disj_nxt;
  logic [CW-1:0]  match_r, match_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [47:0] dnum_r, wnum_r, dterm_r;
  logic        phase_r;
  result_t     res_r;
  logic        accept, div_start, div_done;
  logic [47:0] div_num, quot;
  logic [16:0] div_den;
  logic [CW-1:0] longer;
  logic signed [16:0] wdiff;
  logic [16:0] adiff;
  logic [48:0] total;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign longer = (cnt_a_r > cnt_b_r) ? cnt_a_r : cnt_b_r;
  assign wdiff = $signed({wa_q[15], wa_q}) - $signed({wb_q[15], wb_q});
  assign adiff = wdiff[16] ? 17'(-wdiff) : 17'(wdiff);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfac_r   <= 16'd256;
      wfac_r   <= 16'd256;
      thresh_r <= 9'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DFAC:   dfac_r   <= cfg_data;
        CFG_WFAC:   wfac_r   <= cfg_data;
        CFG_THRESH: thresh_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // List memories: append on load items, read at the merge pointers.
  always_ff @(posedge clk) begin
    if (accept && in_ch.kind == KIND_FIRST && cnt_a_r < CW'(MAX_EDGES)) begin
      id_a_mem[cnt_a_r[AW-1:0]] <= in_ch.innovation_id;
      w_a_mem[cnt_a_r[AW-1:0]]  <= in_ch.edge_weight;
    end
    if (accept && in_ch.kind == KIND_SECOND && cnt_b_r < CW'(MAX_EDGES)) begin
      id_b_mem[cnt_b_r[AW-1:0]] <= in_ch.innovation_id;
      w_b_mem[cnt_b_r[AW-1:0]]  <= in_ch.edge_weight;
    end
    ida_q <= id_a_mem[i_nxt[AW-1:0]];
    wa_q  <= w_a_mem[i_nxt[AW-1:0]];
    idb_q <= id_b_mem[j_nxt[AW-1:0]];
    wb_q  <= w_b_mem[j_nxt[AW-1:0]];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && in_ch.kind == KIND_COMPUTE) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_MERGE;
      ST_MERGE: if (!(i_r < cnt_a_r && j_r < cnt_b_r)) state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   if (div_done && phase_r) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Merge step: pointers advance so that the read issued now meets the next step.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    disj_nxt = disj_r;
    match_nxt = match_r;
    sum_nxt = sum_r;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0; j_nxt = '0; disj_nxt = '0; match_nxt = '0; sum_nxt = '0;
      end
      ST_MERGE: begin
        if (i_r < cnt_a_r && j_r < cnt_b_r) begin
          if (ida_q == idb_q) begin
            i_nxt = i_r + 1'b1;
            j_nxt = j_r + 1'b1;
            match_nxt = match_r + 1'b1;
            sum_nxt = sum_r + SW'(adiff);
          end else begin
            if (ida_q < idb_q) i_nxt = i_r + 1'b1;
            else j_nxt = j_r + 1'b1;
            disj_nxt = disj_r + 1'b1;
          end
        end else begin
          disj_nxt = disj_r + DCW'(cnt_a_r - i_r) + DCW'(cnt_b_r - j_r);
        end
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == ST_MUL) || (state_r == ST_DIV && div_done && !phase_r);
  assign div_num = (state_r == ST_MUL) ? dnum_r : wnum_r;
  always_comb begin
    if (state_r == ST_MUL)
      div_den = (longer != '0 && 32'(longer) >= 32'(thresh_r)) ? 17'(longer) : 17'd1;
    else
      div_den = (match_r != '0) ? 17'({match_r, 4'b0}) : 17'd1;
  end
  assign total = {1'b0, dterm_r} + {1'b0, quot};

  gcd_div #(.NW(48), .DW(17)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_ch.kind == KIND_FIRST && cnt_a_r < CW'(MAX_EDGES))
        cnt_a_r <= cnt_a_r + 1'b1;
      if (accept && in_ch.kind == KIND_SECOND && cnt_b_r < CW'(MAX_EDGES))
        cnt_b_r <= cnt_b_r + 1'b1;
      if (state_r == ST_SUM) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
      end
      if (state_r == ST_MUL) phase_r <= 1'b0;
      else if (state_r == ST_DIV && div_done) phase_r <= 1'b1;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    disj_r <= disj_nxt;
    match_r <= match_nxt;
    sum_r <= sum_nxt;
    // Products registered before they enter the divider.
    if (state_r == ST_PROD) begin
      dnum_r <= 48'(dfac_r) * 48'({disj_r, 8'b0});
      wnum_r <= 48'(wfac_r) * 48'(sum_r);
    end
    if (state_r == ST_DIV && div_done && !phase_r) dterm_r <= quot;
    if (state_r == ST_SUM) begin
      res_r.distance <= (total > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      res_r.disjoint_count <= 10'(disj_r);
      res_r.matching_count <= 9'(match_r);
      res_r.no_matches <= (match_r == '0);
    end
  end

  // Output register drive.
  always_comb begin
    out_ch.valid = (state_r == ST_OUT);
    out_ch.distance = res_r.distance;
    out_ch.disjoint_count = res_r.disjoint_count;
    out_ch.matching_count = res_r.matching_count;
    out_ch.no_matches = res_r.no_matches;
  end

  a_cnt_a: assert property (@(posedge clk) disable iff (!rst_n) cnt_a_r <= CW'(MAX_EDGES))
    else $error("first list length beyond capacity");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE |-> (i_r <= cnt_a_r && j_r <= cnt_b_r))
    else $error("merge pointer past list end");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> (cnt_a_r == '0 && cnt_b_r == '0))
    else $error("lists not cleared after compute");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while result pending");
endmodule
`default_nettype wire

// ===== sv/gcd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gcd_div import gcd_pkg::*; #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  // Shift one numerator bit into the remainder and try a subtraction.
  always_comb begin
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire
